### design/gqt_pkg.sv
// Shared types, constants and helpers for the glyph quad transform unit.
package gqt_pkg;

    localparam int NUM_GLYPHS_DEF = 128;
    localparam int ATLAS_LOG2_DEF = 11;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int PEN_W          = 24;
    localparam int VERTS          = 6;
    localparam int VCNT_W         = 3;
    localparam int OFF_W          = 16;
    localparam int PIX_W          = 12;
    localparam int TEX_W          = 17;
    localparam int ENTRY_W        = 4 * OFF_W + 4 * PIX_W + OFF_W;

    localparam logic [CFG_IDX_W-1:0] REG_MX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MZ    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TXY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TZ    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR = 3'd5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PLACE = 1'b1;

    typedef struct packed {
        logic signed [OFF_W-1:0] left_off;
        logic signed [OFF_W-1:0] top_off;
        logic signed [OFF_W-1:0] right_off;
        logic signed [OFF_W-1:0] bottom_off;
        logic [PIX_W-1:0]        u_min;
        logic [PIX_W-1:0]        v_min;
        logic [PIX_W-1:0]        u_max;
        logic [PIX_W-1:0]        v_max;
        logic [OFF_W-1:0]        advance;
    } glyph_t;

    typedef struct packed {
        logic signed [25:0] cx;
        logic signed [15:0] cy;
        logic [TEX_W-1:0]   tu;
        logic [TEX_W-1:0]   tv;
        logic               last;
    } corner_t;

endpackage

### design/gqt_ram.sv
// Generic single-port-write, registered-read RAM.
module gqt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### design/gqt_xform.sv
// One matrix row times a corner plus translation, floor shift and saturate; products are registered.
module gqt_xform (
    input  logic               clk,
    input  logic               en,
    input  logic [63:0]        row,
    input  logic signed [31:0] t,
    input  logic signed [25:0] cx,
    input  logic signed [15:0] cy,
    output logic signed [31:0] res
);
    logic signed [57:0] pa_reg;
    logic signed [47:0] pb_reg;
    logic signed [31:0] t_reg;
    logic signed [61:0] sum;
    logic signed [55:0] sh;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= 58'(signed'(row[31:0]) * cx);
            pb_reg <= 48'(signed'(row[63:32]) * cy);
            t_reg  <= t;
        end
    end

    always_comb
    begin
        sum = 62'(pa_reg) + 62'(pb_reg) + {{24{t_reg[31]}}, t_reg, 6'd0};
        sh  = 56'(sum >>> 6);
        if (sh > 56'sd2147483647)
            res = 32'sh7FFFFFFF;
        else if (sh < -56'sd2147483648)
            res = 32'sh80000000;
        else
            res = sh[31:0];
    end
endmodule

### design/glyph_quad_transform_unit.sv
// Top level of the glyph quad transform unit.
// A place request passes the s1 RAM read, s2 corner sequencer and s3 output registers before its first vertex.
// Throughput: one vertex per cycle while out_stall is low; each character gives six vertices,
// and input is stalled during its glyph RAM read.
// Load requests are written in the accepting cycle and give no vertex; input stalls
// while a character is read or sequenced, until its last vertex advances.
// Reset clears pen x and control state and sets the config registers to defaults; the glyph RAM is not cleared.
module glyph_quad_transform_unit #(
    parameter int NUM_GLYPHS = gqt_pkg::NUM_GLYPHS_DEF,
    parameter int ATLAS_LOG2 = gqt_pkg::ATLAS_LOG2_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gqt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gqt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [6:0]                       char_code,
    input  logic                             first_char,
    input  logic signed [15:0]               left_off,
    input  logic signed [15:0]               top_off,
    input  logic signed [15:0]               right_off,
    input  logic signed [15:0]               bottom_off,
    input  logic [11:0]                      atlas_u_min,
    input  logic [11:0]                      atlas_v_min,
    input  logic [11:0]                      atlas_u_max,
    input  logic [11:0]                      atlas_v_max,
    input  logic [15:0]                      advance,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [31:0]               pos_x,
    output logic signed [31:0]               pos_y,
    output logic signed [31:0]               pos_z,
    output logic [16:0]                      tex_u,
    output logic [16:0]                      tex_v,
    output logic [31:0]                      color,
    output logic                             last_vertex
);
    import gqt_pkg::*;

    localparam int AW = (NUM_GLYPHS > 1) ? $clog2(NUM_GLYPHS) : 1;
    localparam int SH = 16 - ATLAS_LOG2;

    logic [63:0] mx_reg, my_reg, mz_reg, txy_reg;
    logic [31:0] tz_reg, col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mx_reg  <= 64'd4294967296;
            my_reg  <= 64'hFFFF_FFFF_0000_0000;
            mz_reg  <= '0;
            txy_reg <= '0;
            tz_reg  <= '0;
            col_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MX:    mx_reg  <= cfg_data;
                REG_MY:    my_reg  <= cfg_data;
                REG_MZ:    mz_reg  <= cfg_data;
                REG_TXY:   txy_reg <= cfg_data;
                REG_TZ:    tz_reg  <= cfg_data[31:0];
                REG_COLOR: col_reg <= cfg_data[31:0];
                default:   ;
            endcase
        end
    end

    function automatic logic [128*AW-1:0] gidx_table();
        logic [128*AW-1:0] t;
        for (int i = 0; i < 128; i++)
            t[i*AW +: AW] = AW'(i % NUM_GLYPHS);
        return t;
    endfunction

    localparam logic [128*AW-1:0] GIDX_LUT = gidx_table();

    function automatic logic [AW-1:0] gidx(input logic [6:0] c);
        return GIDX_LUT[32'(c) * AW +: AW];
    endfunction

    function automatic logic [TEX_W-1:0] tex_of(input logic [PIX_W-1:0] p);
        logic [PIX_W+SH:0] t;
        t = (PIX_W+SH+1)'(p) << SH;
        return (t > (PIX_W+SH+1)'(65536)) ? 17'd65536 : TEX_W'(t);
    endfunction

    // stage pipeline: s1 RAM read, s2 corner sequencing, s3 multiply and output
    logic        acc;
    logic        s1_valid_reg, s1_first_reg;
    logic        s2_busy_reg;
    logic [VCNT_W-1:0] vcnt_reg;
    glyph_t      g_reg;
    logic [PEN_W-1:0] pen_reg, base_reg;
    logic        s3_valid_reg;
    corner_t     c3_reg;
    logic        adv;
    glyph_t      wr_entry, rd_entry;

    assign adv = !s3_valid_reg || !out_stall;
    // accept only when the sequencer will be free to take this item
    assign in_stall = s1_valid_reg || (s2_busy_reg && !(adv && vcnt_reg == VCNT_W'(VERTS-1)));
    assign acc = in_valid && !in_stall;

    assign wr_entry = '{left_off, top_off, right_off, bottom_off,
                        atlas_u_min, atlas_v_min, atlas_u_max, atlas_v_max, advance};

    gqt_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_GLYPHS)) u_glyph_ram (
        .clk   (clk),
        .we    (acc && op == OP_LOAD),
        .waddr (gidx(char_code)),
        .wdata (wr_entry),
        .raddr (gidx(char_code)),
        .rdata (rd_entry)
    );

    logic [PEN_W:0] pen_sum;
    logic [PEN_W-1:0] pen_start;
    assign pen_start = s1_first_reg ? '0 : pen_reg;
    assign pen_sum = (PEN_W+1)'(pen_start) + (PEN_W+1)'(rd_entry.advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_first_reg  <= 1'b0;
            s2_busy_reg   <= 1'b0;
            vcnt_reg      <= '0;
            pen_reg       <= '0;
            s3_valid_reg  <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                s1_valid_reg <= (op == OP_PLACE);
                s1_first_reg <= first_char;
            end
            else if (s1_valid_reg)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_valid_reg)
            begin
                pen_reg     <= pen_sum[PEN_W] ? '1 : pen_sum[PEN_W-1:0];
                s2_busy_reg <= 1'b1;
                vcnt_reg    <= '0;
            end
            else if (s2_busy_reg && adv)
            begin
                if (vcnt_reg == VCNT_W'(VERTS-1))
                    s2_busy_reg <= 1'b0;
                vcnt_reg <= vcnt_reg + 1'b1;
            end
            if (adv)
            begin
                s3_valid_reg <= s2_busy_reg && !s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            g_reg    <= rd_entry;
            base_reg <= pen_start;
        end
    end

    corner_t c2;
    logic signed [25:0] xl, xr;
    always_comb
    begin
        xl = signed'(26'(base_reg)) + 26'(g_reg.left_off);
        xr = signed'(26'(base_reg)) + 26'(g_reg.right_off);
        c2.last = 1'b0;
        case (vcnt_reg)
            3'd0, 3'd3: c2 = '{xl, g_reg.bottom_off, tex_of(g_reg.u_min), tex_of(g_reg.v_max), 1'b0};
            3'd1:       c2 = '{xl, g_reg.top_off, tex_of(g_reg.u_min), tex_of(g_reg.v_min), 1'b0};
            3'd2, 3'd4: c2 = '{xr, g_reg.top_off, tex_of(g_reg.u_max), tex_of(g_reg.v_min), 1'b0};
            default:    c2 = '{xr, g_reg.bottom_off, tex_of(g_reg.u_max), tex_of(g_reg.v_max), 1'b1};
        endcase
    end

    logic en2;
    assign en2 = adv && s2_busy_reg && !s1_valid_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c3_reg <= c2;
        end
    end

    gqt_xform u_x (.clk(clk), .en(en2), .row(mx_reg), .t(signed'(txy_reg[31:0])),
                   .cx(c2.cx), .cy(c2.cy), .res(pos_x));
    gqt_xform u_y (.clk(clk), .en(en2), .row(my_reg), .t(signed'(txy_reg[63:32])),
                   .cx(c2.cx), .cy(c2.cy), .res(pos_y));
    gqt_xform u_z (.clk(clk), .en(en2), .row(mz_reg), .t(signed'(tz_reg)),
                   .cx(c2.cx), .cy(c2.cy), .res(pos_z));

    assign out_valid   = s3_valid_reg;
    assign tex_u       = c3_reg.tu;
    assign tex_v       = c3_reg.tv;
    assign color       = col_reg;
    assign last_vertex = c3_reg.last;

    property p_stall_hold;
        @(posedge clk) disable iff (!rst_n) out_valid && out_stall |=> out_valid;
    endproperty
    assert property (p_stall_hold) else $error("output dropped under stall");

    property p_seq_guard;
        @(posedge clk) disable iff (!rst_n) s1_valid_reg |-> in_stall;
    endproperty
    assert property (p_seq_guard) else $error("accept during RAM read");

    property p_cnt_range;
        @(posedge clk) disable iff (!rst_n) s2_busy_reg |-> vcnt_reg < VCNT_W'(VERTS);
    endproperty
    assert property (p_cnt_range) else $error("vertex count out of range");
endmodule

### test/tb_glyph_quad_transform_unit.sv
// Testbench for the glyph quad transform unit: glyph loads, character placement, vertex checks.
`timescale 1ns / 100ps

module tb_glyph_quad_transform_unit;
    import gqt_pkg::*;

    typedef struct {
        logic        op;
        logic [6:0]  char_code;
        logic        first_char;
        logic [15:0] left_off, top_off, right_off, bottom_off;
        logic [11:0] u_min, v_min, u_max, v_max;
        logic [15:0] advance;
    } request_t;

    typedef struct {
        logic [31:0] pos_x, pos_y, pos_z;
        logic [16:0] tex_u, tex_v;
        logic [31:0] color;
        logic        last_vertex;
    } vertex_t;

    localparam int WATCHDOG_LIMIT = 5000;

    logic clk, rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall;
    logic op, first_char, last_vertex;
    logic [6:0] char_code;
    logic signed [15:0] left_off, top_off, right_off, bottom_off;
    logic [11:0] atlas_u_min, atlas_v_min, atlas_u_max, atlas_v_max;
    logic [15:0] advance;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [16:0] tex_u, tex_v;
    logic [31:0] color;

    glyph_quad_transform_unit dut (.*);

    logic [63:0] mat_x, mat_y, mat_z, trans_xy;
    logic [31:0] trans_z, vcolor;
    glyph_t      glyph_table [128];
    bit          glyph_loaded [128];
    logic [23:0] pen;

    request_t pending_requests[$];
    vertex_t  expected_vertices[$];
    int  error_count, vertex_count, place_count, load_count, idle_cycles;
    int  burst_left, gap_left;
    logic request_done;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] transform_row(logic [63:0] row, logic [31:0] t,
                                                  longint x, longint y);
        longint a, b, s, r;
        a = longint'($signed(row[31:0]));
        b = longint'($signed(row[63:32]));
        s = a * x + b * y + longint'($signed(t)) * 64;
        r = s >>> 6;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic logic [16:0] tex_of(logic [11:0] pix);
        logic [31:0] t;
        t = 32'(pix) << (16 - ATLAS_LOG2_DEF);
        return (t > 32'd65536) ? 17'd65536 : t[16:0];
    endfunction

    task automatic predict_request(request_t r);
        glyph_t g;
        longint xs[6], ys[6];
        logic [16:0] us[6], vs[6];
        longint xl, xr, yt, yb;
        logic [24:0] np;
        vertex_t v;
        if (r.op == OP_LOAD)
        begin
            glyph_table[r.char_code] = '{r.left_off, r.top_off, r.right_off, r.bottom_off,
                r.u_min, r.v_min, r.u_max, r.v_max, r.advance};
            glyph_loaded[r.char_code] = 1'b1;
            return;
        end
        if (r.first_char) pen = '0;
        g = glyph_table[r.char_code];
        xl = longint'(pen) + longint'(g.left_off);
        xr = longint'(pen) + longint'(g.right_off);
        yt = longint'(g.top_off);
        yb = longint'(g.bottom_off);
        np = 25'(pen) + 25'(g.advance);
        pen = np[24] ? 24'hFFFFFF : np[23:0];
        xs = '{xl, xl, xr, xl, xr, xr};
        ys = '{yb, yt, yt, yb, yt, yb};
        us = '{tex_of(g.u_min), tex_of(g.u_min), tex_of(g.u_max),
               tex_of(g.u_min), tex_of(g.u_max), tex_of(g.u_max)};
        vs = '{tex_of(g.v_max), tex_of(g.v_min), tex_of(g.v_min),
               tex_of(g.v_max), tex_of(g.v_min), tex_of(g.v_max)};
        for (int k = 0; k < 6; k++)
        begin
            v.pos_x = transform_row(mat_x, trans_xy[31:0], xs[k], ys[k]);
            v.pos_y = transform_row(mat_y, trans_xy[63:32], xs[k], ys[k]);
            v.pos_z = transform_row(mat_z, trans_z, xs[k], ys[k]);
            v.tex_u = us[k];
            v.tex_v = vs[k];
            v.color = vcolor;
            v.last_vertex = (k == 5);
            expected_vertices = {expected_vertices, v};
        end
    endtask

    function automatic request_t load_request(logic [6:0] c, bit extreme);
        request_t r;
        r.op = OP_LOAD;
        r.char_code = c;
        r.first_char = 1'($urandom_range(0, 1));
        if (extreme)
        begin
            r.left_off = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            r.top_off = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            r.right_off = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            r.bottom_off = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            r.u_min = $urandom_range(0, 1) ? 12'hFFF : 12'd0;
            r.v_min = $urandom_range(0, 1) ? 12'hFFF : 12'd2048;
            r.u_max = $urandom_range(0, 1) ? 12'd2048 : 12'hFFF;
            r.v_max = $urandom_range(0, 1) ? 12'd0 : 12'hFFF;
            r.advance = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
        end
        else
        begin
            r.left_off = 16'($urandom);
            r.top_off = 16'($urandom);
            r.right_off = 16'($urandom);
            r.bottom_off = 16'($urandom);
            r.u_min = 12'($urandom);
            r.v_min = 12'($urandom);
            r.u_max = 12'($urandom);
            r.v_max = 12'($urandom);
            r.advance = 16'($urandom);
        end
        return r;
    endfunction

    function automatic request_t place_request(logic [6:0] c, logic first);
        request_t r;
        r = load_request(c, 0);
        r.op = OP_PLACE;
        r.first_char = first;
        return r;
    endfunction

    function automatic logic [6:0] loaded_code();
        logic [6:0] c;
        do c = 7'($urandom_range(0, 127)); while (!glyph_loaded[c]);
        return c;
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MX: mat_x = val;
            REG_MY: mat_y = val;
            REG_MZ: mat_z = val;
            REG_TXY: trans_xy = val;
            REG_TZ: trans_z = val[31:0];
            REG_COLOR: vcolor = val[31:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || expected_vertices.size() != 0 || in_valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // loads go into the predictor shadow only at acceptance, so track loaded codes ahead
    task automatic queue_request(request_t r);
        if (r.op == OP_LOAD) glyph_loaded[r.char_code] = 1'b1;
        pending_requests = {pending_requests, r};
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || request_done)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                request_t r;
                r = pending_requests.pop_front();
                in_valid <= 1'b1;
                op <= r.op;
                char_code <= r.char_code;
                first_char <= r.first_char;
                left_off <= r.left_off;
                top_off <= r.top_off;
                right_off <= r.right_off;
                bottom_off <= r.bottom_off;
                atlas_u_min <= r.u_min;
                atlas_v_min <= r.v_min;
                atlas_u_max <= r.u_max;
                atlas_v_max <= r.v_max;
                advance <= r.advance;
                if (burst_left > 0) burst_left = burst_left - 1;
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= ((vertex_count / 40) % 3 == 2) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        request_t r;
        vertex_t e;
        if (!rst_n)
        begin
            request_done = 1'b0;
        end
        else
        begin
            request_done = in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                r = '{op, char_code, first_char, left_off, top_off, right_off, bottom_off,
                      atlas_u_min, atlas_v_min, atlas_u_max, atlas_v_max, advance};
                predict_request(r);
                if (op == OP_PLACE) place_count++;
                else load_count++;
            end
            if (out_valid && !out_stall)
            begin
                vertex_count++;
                if (expected_vertices.size() == 0)
                begin
                    $error("unexpected vertex pos_x=%h", pos_x);
                    error_count++;
                end
                else
                begin
                    e = expected_vertices.pop_front();
                    if (pos_x !== e.pos_x)
                    begin
                        $error("pos_x expected %h actual %h", e.pos_x, pos_x);
                        error_count++;
                    end
                    if (pos_y !== e.pos_y)
                    begin
                        $error("pos_y expected %h actual %h", e.pos_y, pos_y);
                        error_count++;
                    end
                    if (pos_z !== e.pos_z)
                    begin
                        $error("pos_z expected %h actual %h", e.pos_z, pos_z);
                        error_count++;
                    end
                    if (tex_u !== e.tex_u)
                    begin
                        $error("tex_u expected %h actual %h", e.tex_u, tex_u);
                        error_count++;
                    end
                    if (tex_v !== e.tex_v)
                    begin
                        $error("tex_v expected %h actual %h", e.tex_v, tex_v);
                        error_count++;
                    end
                    if (color !== e.color)
                    begin
                        $error("color expected %h actual %h", e.color, color);
                        error_count++;
                    end
                    if (last_vertex !== e.last_vertex)
                    begin
                        $error("last_vertex expected %b actual %b", e.last_vertex, last_vertex);
                        error_count++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else if (pending_requests.size() != 0 || expected_vertices.size() != 0)
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d vertices outstanding",
                         expected_vertices.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        logic [63:0] settings[6][3];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        request_done = 1'b0;
        {op, char_code, first_char, left_off, top_off, right_off, bottom_off} = '0;
        {atlas_u_min, atlas_v_min, atlas_u_max, atlas_v_max, advance} = '0;
        mat_x = 64'h0000_0001_0000_0000;
        mat_y = 64'hFFFF_FFFF_0000_0000;
        mat_z = '0;
        trans_xy = '0;
        trans_z = '0;
        vcolor = 32'hFFFF_FFFF;
        pen = '0;
        error_count = 0;
        vertex_count = 0;
        place_count = 0;
        load_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_request(load_request(7'd0, 1));
        queue_request(load_request(7'd127, 1));
        queue_request(load_request(7'd64, 0));
        queue_request(place_request(7'd0, 1'b1));
        queue_request(place_request(7'd127, 1'b0));
        queue_request(place_request(7'd64, 1'b0));
        queue_request(load_request(7'd1, 0));
        pending_requests[$].advance = 16'hFFFF;
        for (int i = 0; i < 8; i++) queue_request(place_request(7'd1, 1'b0));
        queue_request(place_request(7'd1, 1'b1));
        queue_request(place_request(7'd127, 1'b1));
        wait_idle();

        settings = '{
            '{64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_8000_0000, 64'h0},
            '{64'h8000_0000_8000_0000, 64'h7FFF_FFFF_7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
            '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_8000_0000},
            '{64'h8000_0000_7FFF_FFFF, 64'h0, 64'h0000_0000_8000_0000},
            '{64'h0000_0000_8000_0000, 64'h0000_0000_7FFF_FFFF, 64'hFFFF_FFFF_0000_0000},
            '{64'h0, 64'hFFFF_FFFF, 64'hA5A5_5A5A}};

        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase < 3)
                for (int reg_i = 0; reg_i < 6; reg_i++)
                    write_register(reg_i[CFG_IDX_W-1:0], settings[reg_i][phase]);
            else
                for (int reg_i = 0; reg_i < 6; reg_i++)
                    write_register(reg_i[CFG_IDX_W-1:0], {$urandom, $urandom});
            for (int n = 0; n < 60; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                    queue_request(load_request(7'($urandom_range(0, 127)),
                                               $urandom_range(0, 5) == 0));
                else
                    queue_request(place_request(loaded_code(), $urandom_range(0, 5) == 0));
            end
            wait_idle();
        end

        $display("covered %0d glyph loads, %0d characters, %0d vertices across 6 settings",
                 load_count, place_count, vertex_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
